FILE: src/chained_range_remap_min_core_defines.svh
// Assertion macros shared by the chained range remap core.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef CHAINED_RANGE_REMAP_MIN_CORE_DEFINES_SVH
`define CHAINED_RANGE_REMAP_MIN_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that is switched off while reset is high.
`define CRRM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also runs during reset.
`define CRRM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRRM_ASSERT(label, clk, rst, prop, msg)
`define CRRM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: src/crrm_pkg.sv
// Shared types and constants of the chained range remap core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package crrm_pkg;

   // Operation codes carried in req_tuser.
   localparam int FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_XLATE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Field widths.
   localparam int STAGE_W = 3;
   localparam int SLOT_W  = 6;
   localparam int WORD_W  = 32;

   // Request tdata layout, lowest bit first.
   localparam int STAGE_LSB   = 0;
   localparam int SLOT_LSB    = STAGE_LSB + STAGE_W;
   localparam int DEST_LSB    = SLOT_LSB + SLOT_W;
   localparam int SRC_LSB     = DEST_LSB + WORD_W;
   localparam int SPAN_LSB    = SRC_LSB + WORD_W;
   localparam int KEY_LSB     = SPAN_LSB + WORD_W;
   localparam int REQ_USED_W  = KEY_LSB + WORD_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout: mapped value, running minimum, seen flag.
   localparam int RSP_USED_W  = 2 * WORD_W + 1;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;  // take a new request into the work registers
      logic              step;     // run the value through the stage at row
      logic              commit;   // apply side effects and load the response
      logic              sweep;    // clear the valid bits of the row
      logic [FUNC_W-1:0] func;     // operation of the item in flight
   } cmd_type;

endpackage

`default_nettype wire

FILE: src/crrm_ctrl.sv
// Controller state machine of the chained range remap core.
// Uses crrm_pkg and the assertion macros in chained_range_remap_min_core_defines.svh.
`default_nettype none
`include "chained_range_remap_min_core_defines.svh"

module crrm_ctrl #(
   parameter int NUM_STAGES = 7,
   localparam int ROW_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic [crrm_pkg::FUNC_W-1:0]   req_func,
   output      logic                          req_tready,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      crrm_pkg::cmd_type             cmd,
   output      logic [ROW_W-1:0]              row
);

   localparam logic [1:0] S_SWEEP  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_XLATE  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_STAGES - 1);

   logic [1:0]                    state_ff, state_in;
   logic [ROW_W-1:0]              cnt_ff, cnt_in;
   logic [crrm_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          last_row;

   assign last_row   = (cnt_ff == LAST_ROW);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign row        = cnt_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.func     = func_ff;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (last_row) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               func_in     = req_func;
               cnt_in      = '0;
               state_in    = (req_func == crrm_pkg::FUNC_XLATE) ? S_XLATE : S_FINISH;
            end
         end
         S_XLATE: begin
            cmd.step = 1'b1;
            if (last_row) begin
               state_in = S_FINISH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               cnt_in       = '0;
               state_in     = (func_ff == crrm_pkg::FUNC_CLEAR) ? S_SWEEP : S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         cnt_ff       <= '0;
         func_ff      <= crrm_pkg::FUNC_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         func_ff      <= func_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CRRM_ASSERT_ALWAYS(a_reset_starts_sweep, clock, reset |=> (state_ff == S_SWEEP && cnt_ff == '0), "reset must start the clearing pass at row zero")
   `CRRM_ASSERT(a_xlate_starts_row0, clock, reset, (req_tvalid && req_tready && req_func == crrm_pkg::FUNC_XLATE) |=> (state_ff == S_XLATE && cnt_ff == '0), "translate must begin at stage zero")
   `CRRM_ASSERT(a_commit_slot_free, clock, reset, cmd.commit |-> (!rsp_valid_ff || rsp_tready), "response overwritten before it was taken")
   `CRRM_ASSERT(a_row_in_range, clock, reset, (state_ff == S_SWEEP || state_ff == S_XLATE) |-> (32'(cnt_ff) < NUM_STAGES), "row counter beyond the last stage")

endmodule

`default_nettype wire

FILE: src/crrm_datapath.sv
// Datapath of the chained range remap core: entry lanes, value and minimum registers.
// Uses crrm_pkg; driven by crrm_ctrl commands.
`default_nettype none

module crrm_datapath #(
   parameter int NUM_STAGES        = 7,
   parameter int ENTRIES_PER_STAGE = 64,
   localparam int ROW_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire crrm_pkg::cmd_type                 cmd,
   input  wire logic [ROW_W-1:0]                  row,
   input  wire logic [crrm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output      logic [crrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int W = crrm_pkg::WORD_W;

   // Work registers of the item in flight.
   logic [crrm_pkg::STAGE_W-1:0] stage_ff;
   logic [crrm_pkg::SLOT_W-1:0]  slot_ff;
   logic [W-1:0]                 dest_ff, src_ff, span_ff;
   logic [W-1:0]                 val_ff, val_in;
   logic [W-1:0]                 min_ff, min_in;
   logic                         seen_ff, seen_in;
   logic [crrm_pkg::RSP_TDATA_W-1:0] rsp_ff;

   logic                         load_ok;
   logic [ROW_W-1:0]             wr_row;
   logic [ENTRIES_PER_STAGE-1:0] hit, first_hit;
   logic [W-1:0]                 cand [ENTRIES_PER_STAGE];
   logic [W-1:0]                 sel_val;
   logic [W-1:0]                 mapped;

   assign load_ok = cmd.commit && (cmd.func == crrm_pkg::FUNC_LOAD)
                    && (32'(stage_ff) < NUM_STAGES) && (32'(slot_ff) < ENTRIES_PER_STAGE);
   assign wr_row  = ROW_W'(stage_ff);

   // One lane per slot; each lane keeps that slot of every stage.
   for (genvar l = 0; l < ENTRIES_PER_STAGE; l++) begin : g_lane
      logic [W-1:0] dest_mem [NUM_STAGES];
      logic [W-1:0] src_mem  [NUM_STAGES];
      logic [W-1:0] span_mem [NUM_STAGES];
      logic         vld_mem  [NUM_STAGES];
      logic         we;
      logic [W-1:0] rd_src, offset;

      assign we = load_ok && (32'(slot_ff) == l);

      always_ff @(posedge clock) begin
         if (we) begin
            dest_mem[wr_row] <= dest_ff;
            src_mem[wr_row]  <= src_ff;
            span_mem[wr_row] <= span_ff;
         end
      end

      // Cleared by the sweep after reset and after a clear operation.
      always_ff @(posedge clock) begin
         if (cmd.sweep) begin
            vld_mem[row] <= 1'b0;
         end else if (we) begin
            vld_mem[wr_row] <= 1'b1;
         end
      end

      // Window test as value >= start and value - start < span, so the end never wraps.
      assign rd_src  = src_mem[row];
      assign offset  = val_ff - rd_src;
      assign hit[l]  = vld_mem[row] && (val_ff >= rd_src) && (offset < span_mem[row]);
      assign cand[l] = dest_mem[row] + offset;
   end

   // The lowest slot wins: isolate the lowest set bit of the hit vector.
   assign first_hit = hit & (~hit + 1'b1);

   always_comb begin
      sel_val = '0;
      for (int l = 0; l < ENTRIES_PER_STAGE; l++) begin
         sel_val = sel_val | ({W{first_hit[l]}} & cand[l]);
      end
   end

   always_comb begin
      val_in = val_ff;
      if (cmd.capture) begin
         val_in = req_tdata[crrm_pkg::KEY_LSB +: W];
      end else if (cmd.step && (|hit)) begin
         val_in = sel_val;
      end
   end

   assign mapped = (cmd.func == crrm_pkg::FUNC_XLATE) ? val_ff : '0;

   always_comb begin
      min_in  = min_ff;
      seen_in = seen_ff;
      if (cmd.commit) begin
         case (cmd.func)
            crrm_pkg::FUNC_XLATE: begin
               min_in  = (val_ff < min_ff) ? val_ff : min_ff;
               seen_in = 1'b1;
            end
            crrm_pkg::FUNC_CLEAR: begin
               min_in  = '1;
               seen_in = 1'b0;
            end
            default: begin
               min_in  = min_ff;
               seen_in = seen_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '1;
         seen_ff <= 1'b0;
      end else begin
         min_ff  <= min_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (cmd.capture) begin
         stage_ff <= req_tdata[crrm_pkg::STAGE_LSB +: crrm_pkg::STAGE_W];
         slot_ff  <= req_tdata[crrm_pkg::SLOT_LSB +: crrm_pkg::SLOT_W];
         dest_ff  <= req_tdata[crrm_pkg::DEST_LSB +: W];
         src_ff   <= req_tdata[crrm_pkg::SRC_LSB +: W];
         span_ff  <= req_tdata[crrm_pkg::SPAN_LSB +: W];
      end
      if (cmd.commit) begin
         rsp_ff <= {{crrm_pkg::RSP_PAD_W{1'b0}}, seen_in, min_in, mapped};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

`default_nettype wire

FILE: src/chained_range_remap_min_core.sv
// Top level of the chained range remap core with running minimum.
// Instantiates crrm_ctrl and crrm_datapath; uses crrm_pkg.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_tvalid/tready     tuser: func; tdata: stage, slot, dest_begin,
//                                              src_begin, span, key_value
//   rsp_      out        rsp_tvalid/tready     tdata: mapped_value, lowest_seen, any_seen
//
// A translate transfer passes from acceptance to the registered response through a capture
// step, a step through each stage in turn and a commit step. Each stage step is the lane
// compare, where all ENTRIES_PER_STAGE entries of a stage are tested in parallel and the
// lowest matching slot is selected. Load and unknown operations take a capture and a commit
// step; a clear takes the same and then a clearing pass of the valid bits of every stage.
// After reset the same clearing pass runs with req_tready low. The response sits in an
// output register, so a new request is accepted while the previous response waits; the
// commit of the next item stalls until that response is taken.
`default_nettype none

module chained_range_remap_min_core #(
   parameter int NUM_STAGES        = 7,
   parameter int ENTRIES_PER_STAGE = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   // [2:0] stage, [8:3] slot, [40:9] dest_begin, [72:41] src_begin, [104:73] span,
   // [136:105] key_value, [143:137] zero
   input  wire logic [crrm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] func
   input  wire logic [crrm_pkg::FUNC_W-1:0]       req_tuser,
   // Response channel.
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] mapped_value, [63:32] lowest_seen, [64] any_seen, [71:65] zero
   output      logic [crrm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int ROW_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

   crrm_pkg::cmd_type  cmd;
   logic [ROW_W-1:0]   row;

   // The controller sequences capture, stage steps, commit and the clearing pass.
   crrm_ctrl #(
      .NUM_STAGES (NUM_STAGES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .row        (row)
   );

   // The datapath holds the entry lanes, the value in flight and the running minimum.
   crrm_datapath #(
      .NUM_STAGES        (NUM_STAGES),
      .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .row       (row),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
